FILE: rtl/lla_pkg.sv
// Shared types and constants for the Life-like automaton engine.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package lla_pkg;

    // Default board capacity, handed to the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    // Field widths fixed by the command and register definitions.
    localparam int COORD_W    = 7;
    localparam int MASK_W     = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Smallest dimension that still has interior cells.
    localparam logic [COORD_W-1:0] MIN_DIM = 7'd3;

    // Reset values of the configuration registers.
    localparam logic [COORD_W-1:0] RST_WIDTH  = 7'd64;
    localparam logic [COORD_W-1:0] RST_HEIGHT = 7'd64;
    localparam logic [MASK_W-1:0]  RST_STAY   = 9'd12;
    localparam logic [MASK_W-1:0]  RST_BORN   = 9'd8;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_STEP  = 2'd2
    } lla_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOARD_WIDTH  = 2'd0,
        REG_BOARD_HEIGHT = 2'd1,
        REG_STAY_MASK    = 2'd2,
        REG_BORN_MASK    = 2'd3
    } lla_reg_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_WR_WAIT,
        ST_STEP_RUN,
        ST_STEP_LAST
    } lla_state_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               cell_in;
    } lla_cmd_data_t;

    typedef struct packed {
        logic cell_out;
        logic out_of_range;
    } lla_rsp_data_t;

    // Control handed from the sequencer to the generation datapath.
    typedef struct packed {
        logic               shift;
        logic [COORD_W-1:0] width;
        logic [MASK_W-1:0]  stay_mask;
        logic [MASK_W-1:0]  born_mask;
    } lla_gen_ctl_t;

endpackage

FILE: rtl/lla_board_mem.sv
// One board buffer: a row-wide synchronous RAM, one write and one read port.
// Uses lla_pkg only for the default row and column counts.
`timescale 1ns / 1ps

module lla_board_mem
    import lla_pkg::*;
#(
    parameter int ROWS = DEF_MAX_HEIGHT,
    parameter int COLS = DEF_MAX_WIDTH
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [$clog2(ROWS)-1:0] waddr,
    input  logic [COLS-1:0]         wdata,
    input  logic [$clog2(ROWS)-1:0] raddr,
    output logic [COLS-1:0]         rdata
);

    logic [COLS-1:0] mem [ROWS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data is registered; a read of the row being written returns old data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/lla_gen_unit.sv
// Generation datapath: a three-row window and one rule lane per column.
// Depends on lla_pkg for the control struct and field widths.
`timescale 1ns / 1ps

module lla_gen_unit
    import lla_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
)
(
    input  logic                 clk,
    input  lla_gen_ctl_t         ctl,
    input  logic [MAX_WIDTH-1:0] row_in,
    input  logic [MAX_WIDTH-1:0] dst_old,
    output logic [MAX_WIDTH-1:0] new_row
);

    logic [MAX_WIDTH-1:0] top_reg;
    logic [MAX_WIDTH-1:0] mid_reg;
    logic [MAX_WIDTH+1:0] top_pad;
    logic [MAX_WIDTH+1:0] mid_pad;
    logic [MAX_WIDTH+1:0] bot_pad;

    function automatic logic rule_bit(input logic [7:0] nb, input logic self,
                                      input logic [MASK_W-1:0] stay,
                                      input logic [MASK_W-1:0] born);
        logic [3:0]        cnt;
        logic [MASK_W-1:0] mask;
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + {3'b000, nb[i]};
        end
        mask = self ? stay : born;
        return mask[cnt];
    endfunction

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            top_reg <= mid_reg;
            mid_reg <= row_in;
        end
    end

    // Padding with a dead column on each side; edge lanes are never interior.
    assign top_pad = {1'b0, top_reg, 1'b0};
    assign mid_pad = {1'b0, mid_reg, 1'b0};
    assign bot_pad = {1'b0, row_in, 1'b0};

    always_comb
    begin
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            if ((x >= 1) && (x + 1 < int'(ctl.width)))
            begin
                new_row[x] = rule_bit({top_pad[x], top_pad[x+1], top_pad[x+2],
                                       mid_pad[x], mid_pad[x+2],
                                       bot_pad[x], bot_pad[x+1], bot_pad[x+2]},
                                      mid_pad[x+1], ctl.stay_mask, ctl.born_mask);
            end
            else
            begin
                new_row[x] = dst_old[x];
            end
        end
    end

endmodule

FILE: rtl/life_like_automaton_engine_top.sv
// Top level of the Life-like automaton engine: sequencer, registers, buffers.
// Depends on lla_pkg, lla_board_mem and lla_gen_unit.
`timescale 1ns / 1ps

// The engine holds two boards of one-bit cells, each a row-wide RAM of
// MAX_HEIGHT rows by MAX_WIDTH columns, and runs a Life-like rule given by the
// stay and born masks. Every command transaction returns exactly one response
// transaction. After reset the block clears both boards, one row per cycle,
// and stalls commands meanwhile; configuration writes are taken at any time
// but should only be made while the block is idle. An out-of-range read or
// write, an unused command code, and a step on a board narrower or lower
// than three cells answer in the accept cycle, so the response is valid in
// the next cycle. An in-range read registers the row and picks the cell; an
// in-range write does a read-modify-write of one row; either answers from its
// wait state. A step walks the active board one row per cycle through the
// single read port of each buffer, keeping a three-row window and evaluating
// the whole row in parallel lanes, then swaps the boards and answers. One
// command is in flight at a time; the next is accepted as soon as the
// sequencer is idle and the response register is empty or being emptied.
module life_like_automaton_engine_top
    import lla_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  lla_cmd_data_t         cmd,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output lla_rsp_data_t         rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int RA_W  = $clog2(MAX_HEIGHT);
    localparam int CA_W  = $clog2(MAX_WIDTH);
    localparam int REXT_W = COORD_W + RA_W;
    localparam int CEXT_W = COORD_W + CA_W;

    // Configuration registers.
    logic [COORD_W-1:0] board_width_reg;
    logic [COORD_W-1:0] board_height_reg;
    logic [MASK_W-1:0]  stay_mask_reg;
    logic [MASK_W-1:0]  born_mask_reg;

    // Sequencer state.
    lla_state_t         state_reg, state_next;
    logic               active_reg, active_next;
    logic [RA_W-1:0]    clr_row_reg, clr_row_next;
    logic [COORD_W-1:0] rd_row_reg, rd_row_next;
    logic               ret_valid_reg;
    logic [COORD_W-1:0] ret_row_reg;

    // Pending read or write coordinates.
    logic [COORD_W-1:0] pend_col_reg;
    logic [COORD_W-1:0] pend_row_reg;
    logic               pend_val_reg;

    // Response register.
    logic               rsp_valid_reg;
    lla_rsp_data_t      rsp_data_reg;
    logic               rsp_load;
    lla_rsp_data_t      rsp_load_data;

    logic [COORD_W-1:0] w_eff;
    logic [COORD_W-1:0] h_eff;
    logic               cmd_acc;
    logic               cmd_oor;
    logic               issue;
    logic               clr_we;

    logic [REXT_W-1:0]  cmd_row_ext;
    logic [REXT_W-1:0]  pend_row_ext;
    logic [REXT_W-1:0]  rd_row_ext;
    logic [REXT_W-1:0]  rd_m1_ext;
    logic [REXT_W-1:0]  ret_m1_ext;
    logic [CEXT_W-1:0]  pend_col_ext;

    // Port signals seen from the source (active) and destination board.
    logic [RA_W-1:0]      src_raddr, dst_raddr, src_waddr, dst_waddr;
    logic                 src_we, dst_we;
    logic [MAX_WIDTH-1:0] src_wdata, dst_wdata;
    logic [MAX_WIDTH-1:0] src_rdata, dst_rdata;
    logic [MAX_WIDTH-1:0] row_mod;
    logic [MAX_WIDTH-1:0] gen_row;

    // Physical buffer ports.
    logic                 a_we, b_we;
    logic [RA_W-1:0]      a_waddr, b_waddr, a_raddr, b_raddr;
    logic [MAX_WIDTH-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

    lla_gen_ctl_t gen_ctl;

    // Dimensions above capacity are treated as the capacity.
    assign w_eff = (int'(board_width_reg) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH)
                                                      : board_width_reg;
    assign h_eff = (int'(board_height_reg) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT)
                                                        : board_height_reg;

    assign cmd_stall = (state_reg != ST_IDLE) || (rsp_valid_reg && rsp_stall);
    assign cmd_acc   = cmd_valid && !cmd_stall;
    assign cmd_oor   = (cmd.column >= w_eff) || (cmd.row >= h_eff);

    assign cmd_row_ext  = REXT_W'(cmd.row);
    assign pend_row_ext = REXT_W'(pend_row_reg);
    assign rd_row_ext   = REXT_W'(rd_row_reg);
    assign rd_m1_ext    = REXT_W'(rd_row_reg - 7'd1);
    assign ret_m1_ext   = REXT_W'(ret_row_reg - 7'd1);
    assign pend_col_ext = CEXT_W'(pend_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_width_reg  <= RST_WIDTH;
            board_height_reg <= RST_HEIGHT;
            stay_mask_reg    <= RST_STAY;
            born_mask_reg    <= RST_BORN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOARD_WIDTH:  board_width_reg  <= cfg_data[COORD_W-1:0];
                REG_BOARD_HEIGHT: board_height_reg <= cfg_data[COORD_W-1:0];
                REG_STAY_MASK:    stay_mask_reg    <= cfg_data[MASK_W-1:0];
                REG_BORN_MASK:    born_mask_reg    <= cfg_data[MASK_W-1:0];
                default:          board_width_reg  <= board_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            active_reg    <= 1'b0;
            clr_row_reg   <= '0;
            rd_row_reg    <= '0;
            ret_valid_reg <= 1'b0;
            ret_row_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            clr_row_reg   <= clr_row_next;
            rd_row_reg    <= rd_row_next;
            ret_valid_reg <= issue;
            ret_row_reg   <= rd_row_reg;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_acc)
        begin
            pend_col_reg <= cmd.column;
            pend_row_reg <= cmd.row;
            pend_val_reg <= cmd.cell_in;
        end
        if (rsp_load)
        begin
            rsp_data_reg <= rsp_load_data;
        end
    end

    // The pending write replaces one bit of the row just read.
    always_comb
    begin
        row_mod = src_rdata;
        row_mod[pend_col_ext[CA_W-1:0]] = pend_val_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        active_next   = active_reg;
        clr_row_next  = clr_row_reg;
        rd_row_next   = rd_row_reg;
        issue         = 1'b0;
        clr_we        = 1'b0;
        src_raddr     = cmd_row_ext[RA_W-1:0];
        dst_raddr     = rd_m1_ext[RA_W-1:0];
        src_we        = 1'b0;
        src_waddr     = pend_row_ext[RA_W-1:0];
        src_wdata     = row_mod;
        rsp_load      = 1'b0;
        rsp_load_data = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_we = 1'b1;
                if (clr_row_reg == RA_W'(MAX_HEIGHT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_row_next = clr_row_reg + RA_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    unique case (cmd.command)
                        CMD_READ:
                        begin
                            if (cmd_oor)
                            begin
                                rsp_load                   = 1'b1;
                                rsp_load_data.out_of_range = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_RD_WAIT;
                            end
                        end
                        CMD_WRITE:
                        begin
                            if (cmd_oor)
                            begin
                                rsp_load                   = 1'b1;
                                rsp_load_data.out_of_range = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_WR_WAIT;
                            end
                        end
                        CMD_STEP:
                        begin
                            if ((w_eff >= MIN_DIM) && (h_eff >= MIN_DIM))
                            begin
                                state_next  = ST_STEP_RUN;
                                rd_row_next = '0;
                            end
                            else
                            begin
                                // No interior cells: the step is only a swap.
                                active_next = ~active_reg;
                                rsp_load    = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                rsp_load               = 1'b1;
                rsp_load_data.cell_out = src_rdata[pend_col_ext[CA_W-1:0]];
                state_next             = ST_IDLE;
            end
            ST_WR_WAIT:
            begin
                src_we     = 1'b1;
                rsp_load   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_STEP_RUN:
            begin
                // Source row r is read together with destination row r-1.
                src_raddr = rd_row_ext[RA_W-1:0];
                issue     = 1'b1;
                if (rd_row_reg == h_eff - 7'd1)
                begin
                    state_next = ST_STEP_LAST;
                end
                else
                begin
                    rd_row_next = rd_row_reg + 7'd1;
                end
            end
            ST_STEP_LAST:
            begin
                // The last interior row is written at this edge as the boards swap.
                active_next = ~active_reg;
                rsp_load    = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Once two source rows are in the window, each returning row completes
    // the destination row above it.
    assign dst_we    = ret_valid_reg && (ret_row_reg >= 7'd2);
    assign dst_waddr = ret_m1_ext[RA_W-1:0];
    assign dst_wdata = gen_row;

    assign gen_ctl.shift     = ret_valid_reg;
    assign gen_ctl.width     = w_eff;
    assign gen_ctl.stay_mask = stay_mask_reg;
    assign gen_ctl.born_mask = born_mask_reg;

    // Steering between logical source/destination and the two buffers.
    assign src_rdata = active_reg ? b_rdata : a_rdata;
    assign dst_rdata = active_reg ? a_rdata : b_rdata;

    assign a_we    = clr_we || (active_reg ? dst_we : src_we);
    assign a_waddr = clr_we ? clr_row_reg : (active_reg ? dst_waddr : src_waddr);
    assign a_wdata = clr_we ? '0 : (active_reg ? dst_wdata : src_wdata);
    assign a_raddr = active_reg ? dst_raddr : src_raddr;

    assign b_we    = clr_we || (active_reg ? src_we : dst_we);
    assign b_waddr = clr_we ? clr_row_reg : (active_reg ? src_waddr : dst_waddr);
    assign b_wdata = clr_we ? '0 : (active_reg ? src_wdata : dst_wdata);
    assign b_raddr = active_reg ? src_raddr : dst_raddr;

    lla_board_mem #(
        .ROWS (MAX_HEIGHT),
        .COLS (MAX_WIDTH)
    ) u_buf_a (
        .clk   (clk),
        .we    (a_we),
        .waddr (a_waddr),
        .wdata (a_wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    lla_board_mem #(
        .ROWS (MAX_HEIGHT),
        .COLS (MAX_WIDTH)
    ) u_buf_b (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    lla_gen_unit #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_gen (
        .clk     (clk),
        .ctl     (gen_ctl),
        .row_in  (src_rdata),
        .dst_old (dst_rdata),
        .new_row (gen_row)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

endmodule

FILE: rtl/lla_checker.sv
// Port-level checker for the Life-like automaton engine, bound to the top level.
// Depends on lla_pkg and on the ports of life_like_automaton_engine_top.
`timescale 1ns / 1ps

module lla_checker
    import lla_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input lla_cmd_data_t cmd,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input lla_rsp_data_t rsp
);

    logic       cmd_acc;
    logic       rsp_acc;
    logic [1:0] pend_reg;
    logic [1:0] last_cmd_reg;

    assign cmd_acc = cmd_valid && !cmd_stall;
    assign rsp_acc = rsp_valid && !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg     <= '0;
            last_cmd_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, cmd_acc} - {1'b0, rsp_acc};
            if (cmd_acc)
            begin
                last_cmd_reg <= cmd.command;
            end
        end
    end

    // A waiting response holds until it is taken.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed or dropped while stalled");

    // A response always belongs to an accepted command.
    a_no_extra_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without an outstanding command");

    // A new command is taken only when the previous one is answered.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc |-> (pend_reg == 2'd0) || ((pend_reg == 2'd1) && rsp_acc))
        else $error("command accepted while another is outstanding");

    // Only reads return cell data, a step never reports a range error, and no response sets both.
    a_rsp_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((last_cmd_reg == CMD_READ) || !rsp.cell_out)
                   && ((last_cmd_reg != CMD_STEP) || !rsp.out_of_range)
                   && !(rsp.cell_out && rsp.out_of_range))
        else $error("response fields inconsistent with the command");

endmodule

bind life_like_automaton_engine_top lla_checker u_lla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

FILE: test/life_like_automaton_engine_top_tb.sv
// Self-checking testbench for the Life-like automaton engine top level.
// Depends on lla_pkg and life_like_automaton_engine_top; the expected responses
// come from a board model kept inside this file.
`timescale 1ns / 1ps

module life_like_automaton_engine_top_tb;
    import lla_pkg::*;

    // Command code 3 has no member in lla_cmd_t, yet the block must answer it.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Longest stretch of cycles in which no transaction is accepted on either channel.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cmd_valid = 1'b0;
    logic                  cmd_stall;
    lla_cmd_data_t         cmd = '0;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    lla_rsp_data_t         rsp;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Board model: two buffers of cells, row-major with a fixed row pitch.
    bit              cells [0:1][0:DEF_MAX_WIDTH*DEF_MAX_HEIGHT-1];
    bit              live_sel = 1'b0;
    int              board_w = RST_WIDTH;
    int              board_h = RST_HEIGHT;
    logic [MASK_W-1:0] stay_rule = RST_STAY;
    logic [MASK_W-1:0] born_rule = RST_BORN;

    lla_cmd_data_t   pending_cmds [$];
    lla_rsp_data_t   expected_rsp [$];
    int              gap_count = 0;
    int              stall_count = 0;
    int              idle_cycles = 0;
    int              error_count = 0;
    bit              send_idle = 1'b0;
    bit              recv_idle = 1'b0;

    life_like_automaton_engine_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int clip_dim(int d);
        return (d > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : d;
    endfunction

    function automatic int draw_wait(bit on);
        return on ? int'($urandom_range(0, 15)) : 0;
    endfunction

    // Computes the next generation into the inactive buffer, then swaps.
    // Border cells are not touched, so they keep what that buffer held.
    function automatic void advance_generation();
        int w;
        int h;
        int n;
        bit src;
        w = clip_dim(board_w);
        h = clip_dim(board_h);
        src = live_sel;
        if (w >= 3 && h >= 3)
        begin
            for (int y = 1; y < h - 1; y++)
            begin
                for (int x = 1; x < w - 1; x++)
                begin
                    n = 0;
                    for (int dy = -1; dy <= 1; dy++)
                        for (int dx = -1; dx <= 1; dx++)
                            if (dx != 0 || dy != 0)
                                n += cells[src][(y + dy) * DEF_MAX_WIDTH + x + dx];
                    cells[!src][y * DEF_MAX_WIDTH + x] =
                        cells[src][y * DEF_MAX_WIDTH + x] ? stay_rule[n] : born_rule[n];
                end
            end
        end
        live_sel = !src;
    endfunction

    // Applies one command to the board model and returns the response it causes.
    function automatic lla_rsp_data_t board_apply(lla_cmd_data_t c);
        lla_rsp_data_t r;
        int addr;
        r = '0;
        if (c.command == CMD_READ || c.command == CMD_WRITE)
        begin
            if (int'(c.column) >= clip_dim(board_w) || int'(c.row) >= clip_dim(board_h))
                r.out_of_range = 1'b1;
            else
            begin
                addr = int'(c.row) * DEF_MAX_WIDTH + int'(c.column);
                if (c.command == CMD_READ)
                    r.cell_out = cells[live_sel][addr];
                else
                    cells[live_sel][addr] = c.cell_in;
            end
        end
        else if (c.command == CMD_STEP)
            advance_generation();
        return r;
    endfunction

    function automatic void post_cmd(logic [1:0] op, int x, int y, int v);
        lla_cmd_data_t c;
        c.command = op;
        c.column  = x[COORD_W-1:0];
        c.row     = y[COORD_W-1:0];
        c.cell_in = v[0];
        pending_cmds.push_back(c);
    endfunction

    // Command side: the expectation is formed at the edge that accepts the
    // transaction, and the next one follows after its drawn gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
            gap_count <= 0;
        end
        else
        begin : cmd_side
            int gap_now;
            gap_now = gap_count;
            if (cmd_valid && !cmd_stall)
            begin
                expected_rsp.push_back(board_apply(cmd));
                gap_now = draw_wait(send_idle);
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (gap_now == 0 && pending_cmds.size() != 0)
                begin
                    cmd_valid <= 1'b1;
                    cmd       <= pending_cmds.pop_front();
                    gap_count <= 0;
                end
                else
                begin
                    cmd_valid <= 1'b0;
                    gap_count <= (gap_now > 0) ? gap_now - 1 : 0;
                end
            end
        end
    end

    // Response side: each response is checked against the oldest expectation,
    // then the receiver holds stall for its drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall   <= 1'b0;
            stall_count <= 0;
        end
        else
        begin : rsp_side
            int stall_now;
            lla_rsp_data_t want;
            stall_now = stall_count;
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("unexpected response: cell_out %0b out_of_range %0b",
                                 rsp.cell_out, rsp.out_of_range);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.cell_out !== want.cell_out ||
                        rsp.out_of_range !== want.out_of_range)
                    begin
                        error_count++;
                        if (error_count <= REPORT_LIMIT)
                            $display("mismatch %0t: exp %0b/%0b got %0b/%0b %s",
                                     $realtime, want.cell_out, want.out_of_range,
                                     rsp.cell_out, rsp.out_of_range,
                                     "(cell_out/out_of_range)");
                    end
                end
                stall_now = draw_wait(recv_idle);
            end
            if (stall_now > 0)
            begin
                rsp_stall   <= 1'b1;
                stall_count <= stall_now - 1;
            end
            else
            begin
                rsp_stall   <= 1'b0;
                stall_count <= 0;
            end
        end
    end

    // Ends a hung run: counts cycles with no accepted transaction on either side.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Waits until every queued command has been sent and answered.
    task automatic drain();
        while (pending_cmds.size() != 0 || cmd_valid || expected_rsp.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(lla_reg_t idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
    endtask

    // Writes all four registers back to back; only called while the block is idle.
    task automatic load_rules(int w, int h, int stay, int born);
        write_reg(REG_BOARD_WIDTH, w);
        write_reg(REG_BOARD_HEIGHT, h);
        write_reg(REG_STAY_MASK, stay);
        write_reg(REG_BORN_MASK, born);
        @(posedge clk);
        cfg_we    <= 1'b0;
        board_w   = w & 'h7F;
        board_h   = h & 'h7F;
        stay_rule = stay[MASK_W-1:0];
        born_rule = born[MASK_W-1:0];
        @(negedge clk);
    endtask

    // Mostly in-range writes, reads and steps so patterns evolve; the rest are
    // coordinates anywhere in the field range and the unused command code.
    task automatic queue_random(int count);
        int w;
        int h;
        int pick;
        w = clip_dim(board_w);
        h = clip_dim(board_h);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
                post_cmd(CMD_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                         $urandom_range(0, 1));
            else if (pick < 70)
                post_cmd(CMD_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
                         $urandom_range(0, 1));
            else if (pick < 82)
                post_cmd(CMD_STEP, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 1));
            else if (pick < 95)
                post_cmd(2'($urandom_range(0, 1)), $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(0, 1));
            else
                post_cmd(CMD_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, 1));
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset rules on the full board, no idling: edges, refusals, a blinker.
        post_cmd(CMD_READ, 0, 0, 0);
        post_cmd(CMD_READ, 64, 0, 0);
        post_cmd(CMD_READ, 0, 64, 0);
        post_cmd(CMD_WRITE, 127, 127, 1);
        post_cmd(CMD_WRITE, 63, 63, 1);
        post_cmd(CMD_READ, 63, 63, 0);
        post_cmd(CMD_WRITE, 0, 0, 1);
        post_cmd(CMD_WRITE, 0, 0, 0);
        post_cmd(CMD_WRITE, 10, 9, 1);
        post_cmd(CMD_WRITE, 10, 10, 1);
        post_cmd(CMD_WRITE, 10, 11, 1);
        post_cmd(CMD_UNUSED, 127, 127, 1);
        post_cmd(CMD_STEP, 0, 0, 0);
        post_cmd(CMD_READ, 9, 10, 0);
        post_cmd(CMD_READ, 10, 9, 0);
        post_cmd(CMD_READ, 63, 63, 0);
        post_cmd(CMD_STEP, 0, 0, 0);
        post_cmd(CMD_READ, 10, 9, 0);
        drain();

        // A board two columns wide has no interior, so a step only swaps buffers.
        load_rules(2, 127, 0, 511);
        post_cmd(CMD_WRITE, 1, 5, 1);
        post_cmd(CMD_STEP, 0, 0, 0);
        post_cmd(CMD_READ, 1, 5, 0);
        post_cmd(CMD_READ, 2, 5, 0);
        drain();

        // Zero dimensions refuse every access.
        load_rules(0, 0, 511, 0);
        post_cmd(CMD_WRITE, 0, 0, 1);
        post_cmd(CMD_READ, 0, 0, 0);
        post_cmd(CMD_STEP, 0, 0, 0);
        drain();

        // Oversized width clips to the capacity; three rows give one interior row.
        load_rules(127, 3, 511, 511);
        post_cmd(CMD_WRITE, 1, 0, 1);
        post_cmd(CMD_STEP, 0, 0, 0);
        post_cmd(CMD_READ, 1, 1, 0);
        post_cmd(CMD_READ, 63, 1, 0);
        post_cmd(CMD_READ, 64, 2, 0);
        drain();

        // Random batches, each under its own rules and idling mix.  Every batch
        // starts only after the previous one has been fully answered.
        for (int batch = 0; batch < 5; batch++)
        begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
            if (batch == 2)
                load_rules(64, 64, $urandom_range(0, 511), $urandom_range(0, 511));
            else if (batch == 0)
                load_rules($urandom_range(3, 12), $urandom_range(3, 12), 12, 8);
            else
                load_rules($urandom_range(3, 12), $urandom_range(3, 12),
                           $urandom_range(0, 511), $urandom_range(0, 511));
            queue_random(24);
            drain();
        end

        // A step is the slowest command; give any stray response time to show up.
        repeat (DEF_MAX_HEIGHT + 8) @(negedge clk);
        if (expected_rsp.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
